// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ipl_pkg.sv
// ----------------------------------------------------------------------------
// ipl_pkg
// shared types, constants and the log2 table builder of the indoor path loss
// ----------------------------------------------------------------------------
package ipl_pkg;

  localparam int LOG_TABLE_BITS_DEF = 6;
  localparam int FRAC_BITS_DEF      = 8;

  localparam int FLOOR_W = 8;
  localparam int DIST_W  = 24;
  localparam int FREQ_W  = 17;
  localparam int TX_W    = 17;
  localparam int OUT_W   = 20;
  localparam int LOG_W   = 21;   // log2 in q16 of up to 24 bit inputs
  localparam int COEF_W  = 5;
  localparam int LF_W    = 11;

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(2160);

  localparam logic [COEF_W-1:0] COEF_RES  = COEF_W'(28);
  localparam logic [COEF_W-1:0] COEF_OFF  = COEF_W'(30);
  localparam logic [COEF_W-1:0] COEF_COM  = COEF_W'(22);
  localparam int                LF_OFF_BASE = 15;
  localparam int                LF_COM_BASE = 6;
  localparam int                LF_BIAS_DB  = 28;

  // log10(2) in q24
  localparam int LOG10_2_Q24 = 5050445;

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  typedef enum logic [1:0] {
    BT_RESIDENTIAL = 2'd0,
    BT_OFFICE      = 2'd1,
    BT_COMMERCIAL  = 2'd2,
    BT_UNKNOWN     = 2'd3
  } building_e;

  // per-item data that rides alongside the log units
  typedef struct packed {
    logic [COEF_W-1:0]      coef;
    logic [LF_W-1:0]        lf;
    logic signed [TX_W-1:0] tx;
    logic                   unknown;
    logic                   clamped;
  } side_t;

  // log2(1 + idx/2^tb) in q16 by repeated squaring of a q30 mantissa
  function automatic logic [16:0] log_rom_entry(int unsigned idx, int unsigned tb);
    logic [63:0] y;
    logic [16:0] acc;
    if (idx == (32'd1 << tb)) begin
      return 17'h10000;
    end
    y   = 64'((32'd1 << tb) + idx) << (30 - tb);
    acc = '0;
    for (int k = 0; k < 16; k++) begin
      y   = (y * y) >> 30;
      acc = acc << 1;
      if (y >= 64'h8000_0000) begin
        y      = y >> 1;
        acc[0] = 1'b1;
      end
    end
    return acc;
  endfunction

endpackage

// File: rtl/core/ipl_log2.sv
// ----------------------------------------------------------------------------
// ipl_log2
// three-stage fixed-point log2 in q16: normalize, table read, interpolate
// ----------------------------------------------------------------------------
module ipl_log2 #(
  parameter int XW = 24,
  parameter int T  = 6,
  parameter int F  = 8,
  parameter int LW = 21
) (
  input  logic          clk_i,
  input  logic [2:0]    en_i,
  input  logic [XW-1:0] x_i,
  output logic [LW-1:0] log2_o
);
  import ipl_pkg::*;

  localparam int EW = $clog2(XW);
  localparam int FW = T + F;
  localparam int PW = ((XW - 1) > FW) ? (XW - 1) : FW;
  localparam int RS = 1 << T;

  logic [16:0]   rom [RS+1];
  logic [EW-1:0] lead;
  logic [XW-1:0] norm;
  logic [PW-1:0] padded;

  logic [EW-1:0] e1_q, e2_q;
  logic [T-1:0]  idx1_q;
  logic [F-1:0]  r1_q, r2_q;
  logic [16:0]   lo2_q, diff2_q;
  logic [16:0]   lo, hi;
  logic [16+F:0] prod;
  logic [16:0]   frac;
  logic [LW-1:0] log3_q;

  for (genvar g = 0; g <= RS; g++) begin : g_rom
    assign rom[g] = log_rom_entry(g, T);
  end

  // leading one position, input is never zero here
  always_comb begin
    lead = '0;
    for (int b = 1; b < XW; b++) begin
      if (x_i[b]) begin
        lead = EW'(b);
      end
    end
  end

  assign norm   = x_i << (EW'(XW - 1) - lead);
  assign padded = PW'(norm[XW-2:0]) << (PW - (XW - 1));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      e1_q   <= lead;
      idx1_q <= padded[PW-1 -: T];
      r1_q   <= padded[PW-1-T -: F];
    end
  end

  assign lo = rom[{1'b0, idx1_q}];
  assign hi = rom[{1'b0, idx1_q} + (T + 1)'(1)];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      e2_q    <= e1_q;
      lo2_q   <= lo;
      diff2_q <= hi - lo;
      r2_q    <= r1_q;
    end
  end

  assign prod = (17 + F)'(diff2_q) * (17 + F)'(r2_q);
  assign frac = lo2_q + 17'(prod >> F);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      log3_q <= (LW'(e2_q) << 16) + LW'(frac);
    end
  end

  assign log2_o = log3_q;

endmodule

// File: rtl/core/ipl_scale.sv
// ----------------------------------------------------------------------------
// ipl_scale
// four-stage weighting of the log terms, log10(2) scaling, rounding, clamp
// ----------------------------------------------------------------------------
module ipl_scale (
  input  logic                                clk_i,
  input  logic [3:0]                          en_i,
  input  logic [ipl_pkg::LOG_W-1:0]           lfreq_i,
  input  logic [ipl_pkg::LOG_W-1:0]           ldist_i,
  input  logic [ipl_pkg::COEF_W-1:0]          coef_i,
  input  logic [ipl_pkg::LF_W-1:0]            lf_i,
  output logic signed [ipl_pkg::OUT_W-1:0]    loss_o,
  output logic                                sat_o
);
  import ipl_pkg::*;

  localparam int DW  = LOG_W + 1;             // log2 distance less 8, signed
  localparam int TDW = DW + COEF_W + 1;       // coef times distance term
  localparam int TFW = LOG_W + 5;             // 20 times frequency term
  localparam int AW  = TDW + 1;
  localparam int KW  = 24;
  localparam int PW  = AW + KW;
  localparam int RW  = PW - 32;
  localparam int LTW = 21;                    // floor term in 1/256 dB
  localparam int SW  = ((RW > LTW) ? RW : LTW) + 1;

  localparam logic signed [KW-1:0] K_LOG10_2 = KW'(LOG10_2_Q24);
  localparam logic signed [PW-1:0] HALF      = PW'(64'd1 << 31);
  localparam logic signed [DW-1:0] DIST_OFS  = DW'(8 << 16);

  logic signed [DW-1:0]  ldist_s;
  logic signed [TDW-1:0] td;
  logic [TFW-1:0]        tf;
  logic signed [TDW-1:0] td4_q;
  logic [TFW-1:0]        tf4_q;
  logic signed [AW-1:0]  a5_q;
  logic signed [PW-1:0]  p6_q;
  logic signed [PW-1:0]  p_rnd;
  logic signed [RW-1:0]  rnd;
  logic signed [12:0]    lfd;
  logic signed [LTW-1:0] lft;
  logic signed [SW-1:0]  tot;
  logic signed [OUT_W-1:0] loss_d, loss7_q;
  logic                  sat_d, sat7_q;

  assign ldist_s = signed'({1'b0, ldist_i}) - DIST_OFS;
  assign td      = signed'({1'b0, coef_i}) * ldist_s;
  assign tf      = (TFW'(lfreq_i) << 4) + (TFW'(lfreq_i) << 2);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      td4_q <= td;
      tf4_q <= tf;
    end
    if (en_i[1]) begin
      a5_q <= AW'(td4_q) + signed'(AW'(tf4_q));
    end
    if (en_i[2]) begin
      p6_q <= PW'(a5_q) * PW'(K_LOG10_2);
    end
  end

  // round half up, then add the floor loss less the 28 dB bias
  assign p_rnd = p6_q + HALF;
  assign rnd   = signed'(p_rnd[PW-1:32]);
  assign lfd   = signed'({2'b00, lf_i}) - 13'sd28;
  assign lft   = signed'({lfd, 8'b0});
  assign tot   = SW'(rnd) + SW'(lft);

  always_comb begin
    loss_d = tot[OUT_W-1:0];
    sat_d  = 1'b0;
    if (tot > SW'(OUT_MAX)) begin
      loss_d = OUT_W'(OUT_MAX);
      sat_d  = 1'b1;
    end else if (tot < SW'(OUT_MIN)) begin
      loss_d = OUT_W'(OUT_MIN);
      sat_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      loss7_q <= loss_d;
      sat7_q  <= sat_d;
    end
  end

  assign loss_o = loss7_q;
  assign sat_o  = sat7_q;

endmodule

// File: rtl/core/indoor_path_loss_itu1238.sv
// throughput: one request per cycle while the master side takes results; nine register stages each take one item
// a stalled master side backs up stage by stage, bubbles are squeezed out
// reset clears all stage valid bits and sets the frequency register to 2160 MHz
// ----------------------------------------------------------------------------
// indoor_path_loss_itu1238
// indoor link loss and received power per request, log2 table based
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indoor_path_loss_itu1238 #(
  parameter int LOG_TABLE_BITS = ipl_pkg::LOG_TABLE_BITS_DEF,
  parameter int FRAC_BITS      = ipl_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ipl_pkg::FREQ_W-1:0]   cfg_data_i,    // frequency_mhz
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // floor_a[7:0], floor_b[15:8], building_type[17:16], distance[41:18],
  // tx_power[58:42], zero[63:59]
  input  logic [63:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // loss_db[19:0], rx_power[39:20]
  output logic [39:0]                  m_axis_tdata,
  // unknown_type[0], distance_clamped[1], saturated[2]
  output logic [2:0]                   m_axis_tuser
);
  import ipl_pkg::*;

  localparam int LAST = 8;

  logic [LAST:0]        en;
  logic [LAST:0]        valid_q;
  logic [FREQ_W-1:0]    freq_q;

  logic [FLOOR_W-1:0]   fa0_q, fb0_q;
  logic [1:0]           bt0_q;
  logic [DIST_W-1:0]    dist0_q;
  logic [TX_W-1:0]      tx0_q;

  logic [FLOOR_W-1:0]   n;
  logic [LF_W-1:0]      n_w;
  side_t                side_d;
  side_t                side_q [1:7];
  logic [DIST_W-1:0]    dist_d;
  logic [FREQ_W-1:0]    freq_d;
  logic [LOG_W-1:0]     lfreq, ldist;
  logic signed [OUT_W-1:0] loss7;
  logic                 sat7;

  logic signed [OUT_W:0]   rx_tot;
  logic signed [OUT_W-1:0] rx_d;
  logic                    rx_sat;
  logic signed [OUT_W-1:0] loss8_q, rx8_q;
  logic [2:0]              user8_q;

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      freq_q <= cfg_data_i;
    end
  end

  // per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[LAST] = !valid_q[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 0: request register
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fa0_q   <= s_axis_tdata[7:0];
      fb0_q   <= s_axis_tdata[15:8];
      bt0_q   <= s_axis_tdata[17:16];
      dist0_q <= s_axis_tdata[41:18];
      tx0_q   <= s_axis_tdata[58:42];
    end
  end

  assign n   = (fa0_q > fb0_q) ? (fa0_q - fb0_q) : (fb0_q - fa0_q);
  assign n_w = LF_W'(n);

  always_comb begin
    side_d         = '0;
    side_d.tx      = signed'(tx0_q);
    side_d.clamped = (dist0_q == '0);
    case (building_e'(bt0_q))
      BT_RESIDENTIAL: begin
        side_d.coef = COEF_RES;
        side_d.lf   = n_w << 2;
      end
      BT_OFFICE: begin
        side_d.coef = COEF_OFF;
        // 15 + 4(n-1) is 4n + 11
        side_d.lf   = (n == '0) ? '0 : (n_w << 2) + LF_W'(LF_OFF_BASE - 4);
      end
      BT_COMMERCIAL: begin
        side_d.coef = COEF_COM;
        // 6 + 3(n-1) is 3n + 3
        side_d.lf   = (n == '0) ? '0 : (n_w << 1) + n_w + LF_W'(LF_COM_BASE - 3);
      end
      default: begin
        side_d.unknown = 1'b1;
      end
    endcase
  end

  assign dist_d = (dist0_q == '0) ? DIST_W'(1) : dist0_q;
  assign freq_d = (freq_q == '0) ? FREQ_W'(1) : freq_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1] <= side_d;
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stages 1 to 3: log2 of distance and frequency
  ipl_log2 #(
    .XW (DIST_W),
    .T  (LOG_TABLE_BITS),
    .F  (FRAC_BITS),
    .LW (LOG_W)
  ) u_log_dist (
    .clk_i  (clk_i),
    .en_i   (en[3:1]),
    .x_i    (dist_d),
    .log2_o (ldist)
  );

  ipl_log2 #(
    .XW (FREQ_W),
    .T  (LOG_TABLE_BITS),
    .F  (FRAC_BITS),
    .LW (LOG_W)
  ) u_log_freq (
    .clk_i  (clk_i),
    .en_i   (en[3:1]),
    .x_i    (freq_d),
    .log2_o (lfreq)
  );

  // stages 4 to 7: weighting, scaling and loss clamp
  ipl_scale u_scale (
    .clk_i   (clk_i),
    .en_i    (en[7:4]),
    .lfreq_i (lfreq),
    .ldist_i (ldist),
    .coef_i  (side_q[3].coef),
    .lf_i    (side_q[6].lf),
    .loss_o  (loss7),
    .sat_o   (sat7)
  );

  // stage 8: received power and output register
  assign rx_tot = (OUT_W + 1)'(side_q[7].tx) - (OUT_W + 1)'(loss7);

  always_comb begin
    rx_d   = rx_tot[OUT_W-1:0];
    rx_sat = 1'b0;
    if (rx_tot > (OUT_W + 1)'(OUT_MAX)) begin
      rx_d   = OUT_W'(OUT_MAX);
      rx_sat = 1'b1;
    end else if (rx_tot < (OUT_W + 1)'(OUT_MIN)) begin
      rx_d   = OUT_W'(OUT_MIN);
      rx_sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      loss8_q <= loss7;
      rx8_q   <= rx_d;
      user8_q <= {sat7 || rx_sat, side_q[7].clamped, side_q[7].unknown};
    end
  end

  assign m_axis_tvalid = valid_q[LAST];
  assign m_axis_tdata  = {rx8_q, loss8_q};
  assign m_axis_tuser  = user8_q;

  `ASSERT_IMP(a_sat_at_limit, m_axis_tvalid && m_axis_tuser[2], (loss8_q == OUT_W'(OUT_MAX)) || (loss8_q == OUT_W'(OUT_MIN)) || (rx8_q == OUT_W'(OUT_MAX)) || (rx8_q == OUT_W'(OUT_MIN)), "saturated flag without a clamped value")
  `ASSERT_IMP(a_stall_needs_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled while the output side is free")
  `ASSERT_NXT(a_stage_holds, valid_q[7] && !en[7], valid_q[7], "stalled stage dropped its item")

endmodule

// File: tb/ipl_link_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipl_link_checker
// watches the config, request and result channels of the indoor path loss
// block, predicts loss, received power and flags per accepted request and
// compares every result against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module ipl_link_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [16:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic [2:0]  m_tuser_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int          TABLE_BITS   = ipl_pkg::LOG_TABLE_BITS_DEF;
  localparam int          INTERP_BITS  = ipl_pkg::FRAC_BITS_DEF;
  localparam longint      LOG10_OF_TWO = 5050445;  // q24
  localparam longint      LOSS_HI      = 524287;
  localparam longint      LOSS_LO      = -524288;
  localparam logic [16:0] FREQ_AT_RESET = 17'd2160;

  typedef struct packed {
    logic signed [19:0] loss_db;
    logic signed [19:0] rx_power;
    logic               unknown_type;
    logic               distance_clamped;
    logic               saturated;
  } link_result_t;

  longint unsigned log2_table [0:(1 << TABLE_BITS)];
  link_result_t    expected_links_q [$];
  logic [16:0]     freq_mhz;

  // log2(1 + i/2^T) in q16, one bit per squaring of a q30 mantissa
  initial begin
    longint unsigned y;
    longint unsigned bits;
    for (int i = 0; i < (1 << TABLE_BITS); i++) begin
      y    = longint'((1 << TABLE_BITS) + i) << (30 - TABLE_BITS);
      bits = 0;
      for (int k = 0; k < 16; k++) begin
        y    = (y * y) >> 30;
        bits = bits << 1;
        if (y >= (64'd1 << 31)) begin
          y    = y >> 1;
          bits = bits | 1;
        end
      end
      log2_table[i] = bits;
    end
    log2_table[1 << TABLE_BITS] = 65536;
    fail_count_o = 0;
    pending_o    = 0;
    freq_mhz     = FREQ_AT_RESET;
  end

  function automatic longint log2_q16(longint unsigned x);
    int              e;
    longint unsigned m, idx, r, lo, hi;
    e = 0;
    for (int b = 0; b < 40; b++)
      if (x[b]) e = b;
    m   = (x << (40 - e)) & ((64'd1 << 40) - 1);
    idx = (m >> (40 - TABLE_BITS)) & ((64'd1 << TABLE_BITS) - 1);
    r   = (m >> (40 - TABLE_BITS - INTERP_BITS)) & ((64'd1 << INTERP_BITS) - 1);
    lo  = log2_table[idx];
    hi  = log2_table[idx + 1];
    return longint'(e) * 65536 + longint'(lo + (((hi - lo) * r) >> INTERP_BITS));
  endfunction

  function automatic link_result_t predict_link_loss(logic [63:0] word, logic [16:0] freq);
    logic [7:0]         fa, fb;
    ipl_pkg::building_e btype;
    logic [23:0]        distance;
    logic signed [16:0] tx;
    longint             n, coef, lf, lfreq, ldist, sum, loss, rx;
    link_result_t       res;
    fa       = word[7:0];
    fb       = word[15:8];
    btype    = ipl_pkg::building_e'(word[17:16]);
    distance = word[41:18];
    tx       = word[58:42];
    res      = '0;
    n     = (fa > fb) ? longint'(fa) - longint'(fb) : longint'(fb) - longint'(fa);
    coef  = 0;
    lf    = 0;
    case (btype)
      ipl_pkg::BT_RESIDENTIAL: begin
        coef = 28;
        lf   = 4 * n;
      end
      ipl_pkg::BT_OFFICE: begin
        coef = 30;
        lf   = (n >= 1) ? 15 + 4 * (n - 1) : 0;
      end
      ipl_pkg::BT_COMMERCIAL: begin
        coef = 22;
        lf   = (n >= 1) ? 6 + 3 * (n - 1) : 0;
      end
      default: begin
        res.unknown_type = 1'b1;
      end
    endcase
    if (distance == 0) begin
      distance             = 24'd1;
      res.distance_clamped = 1'b1;
    end
    if (freq == 0) freq = 17'd1;
    lfreq = log2_q16(longint'(freq));
    // distance is in 1/256 m, so take off 8 octaves
    ldist = log2_q16(longint'(distance)) - (longint'(8) << 16);
    sum   = 20 * 256 * lfreq * LOG10_OF_TWO + coef * 256 * ldist * LOG10_OF_TWO
          + (lf - 28) * 256 * (longint'(1) << 40);
    // round half up, floor on the arithmetic shift
    loss = (sum + (longint'(1) << 39)) >>> 40;
    if (loss > LOSS_HI) begin
      loss = LOSS_HI;
      res.saturated = 1'b1;
    end else if (loss < LOSS_LO) begin
      loss = LOSS_LO;
      res.saturated = 1'b1;
    end
    rx = longint'(tx) - loss;
    if (rx > LOSS_HI) begin
      rx = LOSS_HI;
      res.saturated = 1'b1;
    end else if (rx < LOSS_LO) begin
      rx = LOSS_LO;
      res.saturated = 1'b1;
    end
    res.loss_db  = loss[19:0];
    res.rx_power = rx[19:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    link_result_t got, want;
    if (!rst_ni) begin
      freq_mhz = FREQ_AT_RESET;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tdata_i[19:0], m_tdata_i[39:20], m_tuser_i[0], m_tuser_i[1], m_tuser_i[2]};
        if (expected_links_q.size() == 0) begin
          $error("result with no request outstanding: loss_db %0d rx_power %0d",
                 got.loss_db, got.rx_power);
          fail_count_o++;
        end else begin
          want = expected_links_q.pop_front();
          if (got.loss_db !== want.loss_db) begin
            $error("loss_db mismatch: expected %0d, actual %0d", want.loss_db, got.loss_db);
            fail_count_o++;
          end
          if (got.rx_power !== want.rx_power) begin
            $error("rx_power mismatch: expected %0d, actual %0d", want.rx_power,
                   got.rx_power);
            fail_count_o++;
          end
          if (got.unknown_type !== want.unknown_type) begin
            $error("unknown_type mismatch: expected %0d, actual %0d", want.unknown_type,
                   got.unknown_type);
            fail_count_o++;
          end
          if (got.distance_clamped !== want.distance_clamped) begin
            $error("distance_clamped mismatch: expected %0d, actual %0d",
                   want.distance_clamped, got.distance_clamped);
            fail_count_o++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.saturated,
                   got.saturated);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_links_q.push_back(predict_link_loss(s_tdata_i, freq_mhz));
      if (cfg_valid_i && cfg_ready_i) freq_mhz = cfg_data_i;
    end
    pending_o = expected_links_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random link requests through the indoor path loss
// block across several carrier frequencies, with random idling on both
// sides, and reports the verdict from the link checker
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT   = 2000;
  localparam int PIPE_LATENCY  = 9;
  localparam int PHASE_LINKS   = 165;
  localparam int FREQ_PHASES   = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int fail_count;
  int link_pending;
  int quiet_cycles;
  bit idle_on;

  indoor_path_loss_itu1238 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ipl_link_checker link_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (link_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // floor_a, floor_b, building_type, distance, tx_power from the lowest bit up
  function automatic logic [63:0] pack_link(int fa, int fb, ipl_pkg::building_e bt,
                                            int distance, int tx);
    return {5'd0, 17'(tx), 24'(distance), bt, 8'(fb), 8'(fa)};
  endfunction

  function automatic logic [63:0] random_link();
    int          fa, fb, distance, tx;
    int unsigned sel;
    fa  = $urandom_range(0, 255);
    sel = $urandom_range(0, 9);
    // same floor and adjacent floors sit on the floor loss boundaries
    if (sel < 3) fb = fa;
    else if (sel < 5) fb = (fa == 255) ? 254 : fa + 1;
    else fb = $urandom_range(0, 255);
    sel = $urandom_range(0, 15);
    if (sel == 0) distance = 0;
    else if (sel == 1) distance = 24'hFFFFFF;
    else distance = int'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
    if ($urandom_range(0, 3) == 0) tx = int'($urandom);
    else tx = int'($urandom_range(0, 76800)) - 51200;
    return pack_link(fa, fb, ipl_pkg::building_e'($urandom_range(0, 3)), distance, tx);
  endfunction

  task automatic push_link(input logic [63:0] word);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    while (link_pending != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 3) @(negedge clk_i);
  endtask

  task automatic write_frequency(input logic [16:0] freq);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= freq;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result side backpressure
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [16:0] freq_plan [FREQ_PHASES];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;
    freq_plan     = '{17'd0, 17'd1, 17'd100000, 17'd131071,
                      17'($urandom_range(1, 100000)), 17'($urandom_range(1, 131071))};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed requests at the frequency left by reset
    push_link(pack_link(0, 0, ipl_pkg::BT_RESIDENTIAL, 256, 0));
    push_link(pack_link(0, 0, ipl_pkg::BT_OFFICE, 256, 0));
    push_link(pack_link(0, 0, ipl_pkg::BT_COMMERCIAL, 256, 0));
    push_link(pack_link(0, 0, ipl_pkg::BT_UNKNOWN, 256, 0));
    push_link(pack_link(0, 1, ipl_pkg::BT_OFFICE, 2560, -5120));
    push_link(pack_link(1, 0, ipl_pkg::BT_COMMERCIAL, 2560, 5120));
    push_link(pack_link(255, 0, ipl_pkg::BT_RESIDENTIAL, 24'hFFFFFF, -65536));
    push_link(pack_link(0, 255, ipl_pkg::BT_OFFICE, 24'hFFFFFF, -65536));
    push_link(pack_link(255, 0, ipl_pkg::BT_COMMERCIAL, 24'hFFFFFF, 65535));
    push_link(pack_link(128, 127, ipl_pkg::BT_RESIDENTIAL, 1, 25600));
    push_link(pack_link(0, 0, ipl_pkg::BT_RESIDENTIAL, 0, -51200));
    push_link(pack_link(7, 7, ipl_pkg::BT_UNKNOWN, 0, 65535));
    push_link(pack_link(0, 0, ipl_pkg::BT_OFFICE, 255, 0));
    push_link(pack_link(3, 9, ipl_pkg::BT_OFFICE, 24'h800000, -51200));
    push_link(pack_link(170, 85, ipl_pkg::BT_COMMERCIAL, 24'hAAAAAA, 17'h15555));
    push_link(pack_link(85, 170, ipl_pkg::BT_UNKNOWN, 24'h555555, 17'h0AAAA));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < FREQ_PHASES; p++) begin
      // last phase runs at full rate on both sides
      if (p == FREQ_PHASES - 1) idle_on = 1'b0;
      write_frequency(freq_plan[p]);
      repeat (PHASE_LINKS) push_link(random_link());
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    if (fail_count == 0 && link_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ipl_pkg.sv
rtl/core/ipl_log2.sv
rtl/core/ipl_scale.sv
rtl/core/indoor_path_loss_itu1238.sv
tb/ipl_link_checker.sv
tb/tb_top.sv
